// ----- rtl/dsgb_pkg.sv -----
// Shared constants, register map and item types of the scatter-gather list builder.
package dsgb_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SEGS   = 64;

    // Width of a page offset, and of a chunk length that can reach a full page.
    localparam int PAGE_LOG = $clog2(PAGE_BYTES);
    localparam int CHUNK_W  = PAGE_LOG + 1;

    localparam int ADDR_W  = 40;
    localparam int VADDR_W = 64;
    localparam int LEN_W   = 32;
    localparam int IDX_W   = 6;
    localparam int LIM_W   = 9;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_BOUNDARY  = 2'd0,
        REG_MAX_SEG   = 2'd1,
        REG_SEG_LIMIT = 2'd2,
        REG_ADDR_MASK = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [VADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0]  phys_addr;
        logic [LEN_W-1:0]   bytes_left;
        logic               first_chunk;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        chunk_bytes;
        logic [IDX_W-1:0]   seg_index;
        logic [ADDR_W-1:0]  seg_dev_addr;
        logic [VADDR_W-1:0] seg_virt_addr;
        logic [LEN_W-1:0]   seg_bytes;
        logic               new_segment;
        logic               status;
    } out_item_t;

endpackage

// ----- rtl/dma_scatter_gather_builder.sv -----
// Top level of the scatter-gather list builder: chunk clipping, segment merge and map state.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one buffer chunk per item:
//   virtual address, translated physical address, bytes still to map and a first flag.
//   The output channel (out_valid, out_stall, out_data) returns one item per chunk: the
//   bytes placed, the segment that holds the chunk, its start addresses and length, and
//   whether the chunk opened that segment or hit the segment limit.
//   An item is taken at a clock edge where valid is high and stall is low.
//   The input register is loaded first; the clip/merge logic then runs on it and, when
//   the output can take it, updates the map state and loads the output register.
//   Throughput is one item per cycle while out_stall stays low; the map state updates
//   at the same edge that writes the result, so the next chunk sees it without forwarding.
//   When the receiver stalls, the result holds in the output register and the chunk
//   behind it holds in the input register; in_stall rises only when both are full.
//   Reset clears the map state and both valid flags and loads the register defaults:
//   no boundary, 64 KiB segment maximum, a limit of one segment, no address mask.
//   Registers sit on the APB port at byte addresses 0, 8, 16 and 24 (64-bit data);
//   write them only while no item is in flight.
module dma_scatter_gather_builder
    import dsgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [32:0]         boundary_reg;
    logic [LEN_W-1:0]    max_seg_reg;
    logic [6:0]          seg_limit_reg;
    logic [ADDR_W-1:0]   addr_mask_reg;

    // Map state
    logic [IDX_W-1:0]    cur_idx_reg,   cur_idx_next;
    logic [ADDR_W-1:0]   cur_addr_reg,  cur_addr_next;
    logic [VADDR_W-1:0]  cur_vaddr_reg, cur_vaddr_next;
    logic [LEN_W-1:0]    cur_len_reg,   cur_len_next;
    logic [ADDR_W-1:0]   last_end_reg,  last_end_next;
    logic                ovf_reg,       ovf_next;

    // Pipeline registers
    logic                in_valid_reg;
    in_item_t            in_reg;
    logic                out_valid_reg;
    out_item_t           out_reg,       out_next;

    logic                advance;
    logic                accept;
    logic                cfg_write;
    cfg_reg_t            cfg_sel;

    // Clip datapath
    logic [PAGE_LOG-1:0] page_off;
    logic [CHUNK_W-1:0]  sg_page;
    logic [CHUNK_W-1:0]  sg_left;
    logic [CHUNK_W-1:0]  sg;
    logic [32:0]         boundary_m1;
    logic [ADDR_W-1:0]   bmask;
    logic [ADDR_W:0]     bmask_ext;
    logic [ADDR_W:0]     win_end;
    logic [ADDR_W+1:0]   room;
    logic                boundary_on;
    logic                clip_room;

    // Merge decision
    logic                contig;
    logic [LEN_W:0]      len_sum;
    logic                len_fits;
    logic                same_win;
    logic [LIM_W-1:0]    lim;
    logic                at_limit;
    logic [ADDR_W-1:0]   end_addr;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg  <= '0;
            max_seg_reg   <= 32'd65536;
            seg_limit_reg <= 7'd1;
            addr_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_BOUNDARY:  boundary_reg  <= pwdata[32:0];
                REG_MAX_SEG:   max_seg_reg   <= pwdata[LEN_W-1:0];
                REG_SEG_LIMIT: seg_limit_reg <= pwdata[6:0];
                REG_ADDR_MASK: addr_mask_reg <= pwdata[ADDR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_BOUNDARY:  prdata = {31'd0, boundary_reg};
            REG_MAX_SEG:   prdata = {32'd0, max_seg_reg};
            REG_SEG_LIMIT: prdata = {57'd0, seg_limit_reg};
            REG_ADDR_MASK: prdata = {24'd0, addr_mask_reg};
        endcase
    end

    // Handshake: the output register drains or refills, the input register feeds it.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= in_data;
        if (advance && in_valid_reg)
            out_reg <= out_next;
    end

    // Clip the chunk to the page end, the bytes left and the boundary window.
    // The window end is formed at 41 bits; a negative room means the masked window
    // wrapped below the chunk and clips nothing.
    always_comb
    begin
        page_off    = in_reg.virt_addr[PAGE_LOG-1:0];
        sg_page     = CHUNK_W'(PAGE_BYTES) - {1'b0, page_off};
        sg_left     = (in_reg.bytes_left < LEN_W'(sg_page))
                      ? in_reg.bytes_left[CHUNK_W-1:0] : sg_page;

        boundary_on = (boundary_reg != '0);
        boundary_m1 = boundary_reg - 33'd1;
        bmask       = ~{7'd0, boundary_m1};
        if (addr_mask_reg != '0)
            bmask = bmask & addr_mask_reg;
        bmask_ext   = {(addr_mask_reg == '0), bmask};

        win_end     = ({1'b0, in_reg.phys_addr} + {8'd0, boundary_reg}) & bmask_ext;
        room        = {1'b0, win_end} - {2'b00, in_reg.phys_addr};
        clip_room   = boundary_on && !room[ADDR_W+1]
                      && ((ADDR_W+1)'(sg_left) > room[ADDR_W:0]);
        sg          = clip_room ? room[CHUNK_W-1:0] : sg_left;
    end

    // Merge test and segment limit.
    always_comb
    begin
        contig   = ((last_end_reg + 40'd1) == in_reg.phys_addr);
        len_sum  = {1'b0, cur_len_reg} + (LEN_W+1)'(sg);
        len_fits = (len_sum <= {1'b0, max_seg_reg});
        same_win = !boundary_on
                   || ((cur_addr_reg & bmask) == (in_reg.phys_addr & bmask));

        lim = {2'b00, seg_limit_reg};
        if (lim > LIM_W'(MAX_SEGS))
            lim = LIM_W'(MAX_SEGS);
        if (lim > LIM_W'(64))
            lim = LIM_W'(64);
        at_limit = (({3'd0, cur_idx_reg} + LIM_W'(1)) >= lim);

        end_addr = in_reg.phys_addr + ADDR_W'(sg) - 40'd1;
    end

    // Next map state and the result built from it.
    always_comb
    begin
        cur_idx_next          = cur_idx_reg;
        cur_addr_next         = cur_addr_reg;
        cur_vaddr_next        = cur_vaddr_reg;
        cur_len_next          = cur_len_reg;
        last_end_next         = last_end_reg;
        ovf_next              = ovf_reg;
        out_next.chunk_bytes  = '0;
        out_next.new_segment  = 1'b0;
        out_next.status       = 1'b0;

        priority if (in_reg.first_chunk)
        begin
            // Restart the map at segment zero, no limit check.
            ovf_next             = 1'b0;
            cur_idx_next         = '0;
            cur_addr_next        = in_reg.phys_addr;
            cur_vaddr_next       = in_reg.virt_addr;
            cur_len_next         = LEN_W'(sg);
            last_end_next        = end_addr;
            out_next.chunk_bytes = 13'(sg);
            out_next.new_segment = 1'b1;
        end
        else if (ovf_reg)
        begin
            out_next.status = 1'b1;
        end
        else if (contig && len_fits && same_win)
        begin
            cur_len_next         = len_sum[LEN_W-1:0];
            last_end_next        = end_addr;
            out_next.chunk_bytes = 13'(sg);
        end
        else if (at_limit)
        begin
            ovf_next        = 1'b1;
            out_next.status = 1'b1;
        end
        else
        begin
            cur_idx_next         = cur_idx_reg + 6'd1;
            cur_addr_next        = in_reg.phys_addr;
            cur_vaddr_next       = in_reg.virt_addr;
            cur_len_next         = LEN_W'(sg);
            last_end_next        = end_addr;
            out_next.chunk_bytes = 13'(sg);
            out_next.new_segment = 1'b1;
        end

        out_next.seg_index     = cur_idx_next;
        out_next.seg_dev_addr  = cur_addr_next;
        out_next.seg_virt_addr = cur_vaddr_next;
        out_next.seg_bytes     = cur_len_next;
    end

    // Commit the map state at the edge that loads the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_idx_reg   <= '0;
            cur_addr_reg  <= '0;
            cur_vaddr_reg <= '0;
            cur_len_reg   <= '0;
            last_end_reg  <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (advance && in_valid_reg)
        begin
            cur_idx_reg   <= cur_idx_next;
            cur_addr_reg  <= cur_addr_next;
            cur_vaddr_reg <= cur_vaddr_next;
            cur_len_reg   <= cur_len_next;
            last_end_reg  <= last_end_next;
            ovf_reg       <= ovf_next;
        end
    end

    // A chunk in the input register moves to the output whenever the output can take it.
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("chunk dropped between input and output register");

    // An overflow result places nothing and opens nothing.
    a_overflow_places_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status |-> out_reg.chunk_bytes == '0
                                            && !out_reg.new_segment)
        else $error("overflow result placed bytes");

    // A freshly opened segment holds exactly the chunk that opened it.
    a_open_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.new_segment
            |-> out_reg.seg_bytes == LEN_W'(out_reg.chunk_bytes))
        else $error("opened segment length differs from chunk length");

    // Sticky overflow: once set, only a first chunk clears it.
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(advance && in_valid_reg && in_reg.first_chunk) |=> ovf_reg)
        else $error("overflow cleared without a first chunk");

endmodule
